// File: rtl/bcu_pkg.sv
package bcu_pkg;

	// field widths of the request and result payloads
	localparam int N_WIDTH          = 8;
	localparam int RESULT_WIDTH     = 64;
	// quotient bits produced per cycle by the divide step
	localparam int DIV_BITS_DEFAULT = 8;

	typedef struct packed {
		logic [N_WIDTH-1:0] n_items;
		logic [N_WIDTH-1:0] r_chosen;
	} request_t;

	typedef struct packed {
		logic [RESULT_WIDTH-1:0] coefficient;
		logic                    overflow;
	} result_t;

	// sequencer steps, one control word each
	typedef enum logic [2:0] {
		STEP_IDLE   = 3'd0,
		STEP_SETUP  = 3'd1,
		STEP_TEST   = 3'd2,
		STEP_MUL    = 3'd3,
		STEP_DIV    = 3'd4,
		STEP_UPDATE = 3'd5,
		STEP_FINISH = 3'd6
	} step_t;

	typedef enum logic [2:0] {
		OP_LOAD,
		OP_SETUP,
		OP_NONE,
		OP_MUL,
		OP_DIV,
		OP_UPDATE,
		OP_FINISH
	} ctl_op_t;

	typedef enum logic [2:0] {
		COND_NEVER,
		COND_NO_REQ,
		COND_I_EQ_K,
		COND_DIV_MORE,
		COND_QUOT_FITS,
		COND_OUT_FULL
	} ctl_cond_t;

	typedef struct packed {
		ctl_op_t   op;
		ctl_cond_t cond;
		step_t     jump_step;
		step_t     next_step;
	} ctl_word_t;

	// control store
	function automatic ctl_word_t ucode_rom(input step_t step);
		ctl_word_t cw;
		unique case (step)
			STEP_IDLE:   cw = '{OP_LOAD,   COND_NO_REQ,    STEP_IDLE,   STEP_SETUP};
			STEP_SETUP:  cw = '{OP_SETUP,  COND_NEVER,     STEP_IDLE,   STEP_TEST};
			STEP_TEST:   cw = '{OP_NONE,   COND_I_EQ_K,    STEP_FINISH, STEP_MUL};
			STEP_MUL:    cw = '{OP_MUL,    COND_NEVER,     STEP_IDLE,   STEP_DIV};
			STEP_DIV:    cw = '{OP_DIV,    COND_DIV_MORE,  STEP_DIV,    STEP_UPDATE};
			STEP_UPDATE: cw = '{OP_UPDATE, COND_QUOT_FITS, STEP_TEST,   STEP_FINISH};
			STEP_FINISH: cw = '{OP_FINISH, COND_OUT_FULL,  STEP_FINISH, STEP_IDLE};
			default:     cw = '{OP_NONE,   COND_NEVER,     STEP_IDLE,   STEP_IDLE};
		endcase
		return cw;
	endfunction

endpackage

// File: rtl/binomial_coefficient_unit.sv
// Binomial coefficient unit: for each request (n, r) returns the exact C(n,r)
// as an unsigned RESULT_WIDTH-bit value, 0 when r exceeds n, and all ones with
// overflow set when the true value does not fit. A small microcode sequencer
// runs acc <- acc * (n - i) / (i + 1) for i = 0 .. k-1, k = min(r, n - r), on
// one shared multiplier and one divide unit that retires DIV_BITS quotient bits
// a cycle. A request runs through setup, then per step test, multiply, divide
// and update, then a final test and finish; the divide unit sets the rate. An
// overflowing request stops at the first step that no longer fits. A stalled
// result held in the output register delays only the finish of the next request.
// One request is worked on at a time; a finished result sits in the output
// register while the next request is taken in.
module binomial_coefficient_unit
	import bcu_pkg::*;
#(
	parameter int DIV_BITS = DIV_BITS_DEFAULT
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     request_valid,
	output logic     request_stall,
	input  request_t request,
	output logic     result_valid,
	input  logic     result_stall,
	output result_t  result
);

	// product width, padded divide register width and divide cycle count
	localparam int PW      = RESULT_WIDTH + N_WIDTH;
	localparam int DIV_CYC = (PW + DIV_BITS - 1) / DIV_BITS;
	localparam int DW      = DIV_CYC * DIV_BITS;
	localparam int CNT_W   = (DIV_CYC > 1) ? $clog2(DIV_CYC) : 1;

	// sequencer
	step_t     pc_q, pc_d;
	ctl_word_t cw;
	logic      take_jump;

	// datapath registers
	logic [N_WIDTH-1:0]      n_q, r_q, k_q, i_q;
	logic [RESULT_WIDTH-1:0] acc_q;
	logic                    ovf_q;
	logic [DW-1:0]           div_sh_q;
	logic [N_WIDTH-1:0]      rem_q;
	logic [CNT_W-1:0]        cnt_q;

	// output register
	logic    result_valid_q;
	result_t result_q;

	// combinational datapath values
	logic [N_WIDTH-1:0] mult_n;
	logic [N_WIDTH-1:0] divisor;
	logic [PW-1:0]      prod;
	logic [DW-1:0]      div_sh_nxt;
	logic [N_WIDTH-1:0] rem_nxt;
	logic               quot_fits;
	logic               div_last;
	logic               out_full;
	logic               req_accept;

	assign request_stall = (pc_q != STEP_IDLE);
	assign req_accept    = request_valid && !request_stall;
	assign result_valid  = result_valid_q;
	assign result        = result_q;
	assign out_full      = result_valid_q && result_stall;

	// multiplier factor n - i and divisor i + 1
	assign mult_n  = n_q - i_q;
	assign divisor = i_q + N_WIDTH'(1);
	assign prod    = PW'(acc_q) * PW'(mult_n);

	// quotient fits when nothing lands above the result width
	assign quot_fits = (div_sh_q[DW-1:RESULT_WIDTH] == '0);
	assign div_last  = (cnt_q == CNT_W'(DIV_CYC - 1));

	// restoring divide, DIV_BITS quotient bits a cycle; the remainder stays
	// below the divisor so every trial works on N_WIDTH+1 bits
	always_comb begin
		logic [N_WIDTH:0] trial;
		rem_nxt    = rem_q;
		div_sh_nxt = div_sh_q;
		for (int b = 0; b < DIV_BITS; b++) begin
			trial      = {rem_nxt, div_sh_nxt[DW-1]};
			div_sh_nxt = {div_sh_nxt[DW-2:0], 1'b0};
			if (trial >= {1'b0, divisor}) begin
				rem_nxt       = N_WIDTH'(trial - {1'b0, divisor});
				div_sh_nxt[0] = 1'b1;
			end else begin
				rem_nxt = trial[N_WIDTH-1:0];
			end
		end
	end

	// next step: fetch the control word, test its condition
	always_comb begin
		cw = ucode_rom(pc_q);
		unique case (cw.cond)
			COND_NEVER:     take_jump = 1'b0;
			COND_NO_REQ:    take_jump = !request_valid;
			COND_I_EQ_K:    take_jump = (i_q == k_q);
			COND_DIV_MORE:  take_jump = !div_last;
			COND_QUOT_FITS: take_jump = quot_fits;
			COND_OUT_FULL:  take_jump = out_full;
			default:        take_jump = 1'b0;
		endcase
		pc_d = take_jump ? cw.jump_step : cw.next_step;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= STEP_IDLE;
		end else begin
			pc_q <= pc_d;
		end
	end

	// datapath, driven by the op field of the current control word
	always_ff @(posedge clk) begin
		unique case (cw.op)
			OP_LOAD: begin
				if (req_accept) begin
					n_q <= request.n_items;
					r_q <= request.r_chosen;
				end
			end
			OP_SETUP: begin
				i_q   <= '0;
				ovf_q <= 1'b0;
				if (r_q > n_q) begin
					// empty selection: loop runs zero times and leaves 0
					acc_q <= '0;
					k_q   <= '0;
				end else begin
					acc_q <= RESULT_WIDTH'(1);
					k_q   <= ((n_q - r_q) < r_q) ? (n_q - r_q) : r_q;
				end
			end
			OP_MUL: begin
				div_sh_q <= DW'(prod);
				rem_q    <= '0;
				cnt_q    <= '0;
			end
			OP_DIV: begin
				div_sh_q <= div_sh_nxt;
				rem_q    <= rem_nxt;
				cnt_q    <= cnt_q + CNT_W'(1);
			end
			OP_UPDATE: begin
				if (quot_fits) begin
					acc_q <= div_sh_q[RESULT_WIDTH-1:0];
					i_q   <= i_q + N_WIDTH'(1);
				end else begin
					ovf_q <= 1'b1;
				end
			end
			OP_NONE, OP_FINISH: begin
			end
			default: begin
			end
		endcase
	end

	// output register: loaded at the finish step once the slot is free
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (cw.op == OP_FINISH && !out_full) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cw.op == OP_FINISH && !out_full) begin
			result_q.coefficient <= ovf_q ? '1 : acc_q;
			result_q.overflow    <= ovf_q;
		end
	end

	// an accepted request always starts the setup step
	assert property (@(posedge clk) disable iff (!arst_n)
		req_accept |=> (pc_q == STEP_SETUP))
		else $error("accepted request did not start setup");

	// the loop only multiplies or divides while terms remain
	assert property (@(posedge clk) disable iff (!arst_n)
		(pc_q == STEP_MUL || pc_q == STEP_DIV) |-> (i_q < k_q))
		else $error("loop index ran past its bound");

	// divide remainder stays below the divisor
	assert property (@(posedge clk) disable iff (!arst_n)
		(pc_q == STEP_DIV) |-> (rem_q < divisor))
		else $error("divide remainder not below divisor");

	// a saturated result carries all ones
	assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.overflow) |-> (&result.coefficient))
		else $error("overflow result not saturated");

endmodule

// File: test/binomial_coefficient_unit_tb.sv
`timescale 1ns / 100ps

module binomial_coefficient_unit_tb;
	import bcu_pkg::*;

	// run length and pressure settings
	localparam int RESET_CYCLES  = 4;
	localparam int PHASE_ITEMS   = 400;
	localparam int LONG_HOLD     = 400;
	// quiet time after the last owed result, watched for stray results
	localparam int SETTLE_CYCLES = 500;
	localparam int TIMEOUT_NS    = 40_000_000;

	// per phase idle rates in percent: sender gaps, receiver stalls
	localparam int SEND_GAP_PCT [3] = '{33, 60, 0};
	localparam int RECV_STALL_PCT [3] = '{60, 33, 0};

	localparam logic [RESULT_WIDTH-1:0] SATURATED = '1;
	// widest value the predictor must hold before the fit test
	localparam int WIDE_BITS = 2 * RESULT_WIDTH;
	localparam logic [WIDE_BITS-1:0] COEFF_LIMIT = {{RESULT_WIDTH{1'b0}}, {RESULT_WIDTH{1'b1}}};

	// one row of the directed table: known marks a result typed in by hand
	typedef struct packed {
		logic     known;
		request_t req;
		result_t  res;
	} directed_row_t;

	localparam int DIRECTED_ROWS = 25;
	localparam directed_row_t DIRECTED [DIRECTED_ROWS] = '{
		// empty set and r above n
		'{1'b1, '{8'd0,   8'd0},   '{64'd1,   1'b0}},
		'{1'b1, '{8'd0,   8'd1},   '{64'd0,   1'b0}},
		'{1'b1, '{8'd0,   8'd255}, '{64'd0,   1'b0}},
		// largest n at both ends of r, r just above n, then small n
		'{1'b1, '{8'd255, 8'd0},   '{64'd1,   1'b0}},
		'{1'b1, '{8'd255, 8'd255}, '{64'd1,   1'b0}},
		'{1'b1, '{8'd255, 8'd1},   '{64'd255, 1'b0}},
		'{1'b1, '{8'd255, 8'd254}, '{64'd255, 1'b0}},
		'{1'b1, '{8'd254, 8'd255}, '{64'd0,   1'b0}},
		'{1'b1, '{8'd1,   8'd1},   '{64'd1,   1'b0}},
		'{1'b1, '{8'd1,   8'd0},   '{64'd1,   1'b0}},
		'{1'b1, '{8'd2,   8'd1},   '{64'd2,   1'b0}},
		// far too large, saturates; r above n gives 0
		'{1'b1, '{8'd255, 8'd128}, '{SATURATED, 1'b1}},
		'{1'b1, '{8'd255, 8'd127}, '{SATURATED, 1'b1}},
		'{1'b1, '{8'd170, 8'd85},  '{SATURATED, 1'b1}},
		'{1'b1, '{8'd85,  8'd170}, '{64'd0,     1'b0}},
		'{1'b1, '{8'd128, 8'd64},  '{SATURATED, 1'b1}},
		// left to the predictor, several near the edge of the result width
		'{1'b0, '{8'd67,  8'd33},  '0},
		'{1'b0, '{8'd67,  8'd34},  '0},
		'{1'b0, '{8'd68,  8'd34},  '0},
		'{1'b0, '{8'd64,  8'd32},  '0},
		'{1'b0, '{8'd10,  8'd5},   '0},
		'{1'b0, '{8'd255, 8'd8},   '0},
		'{1'b0, '{8'd255, 8'd9},   '0},
		'{1'b0, '{8'd200, 8'd11},  '0},
		'{1'b0, '{8'd33,  8'd17},  '0}
	};

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     request_valid = 1'b0;
	logic     request_stall;
	request_t request = '0;
	logic     result_valid;
	logic     result_stall = 1'b0;
	result_t  result;

	// coefficients still owed by the block, oldest first
	result_t coefficient_q [$];
	int      mismatch_count = 0;
	int      send_gap_pct = 0;
	int      recv_stall_pct = 0;
	// receiver hold-off, set on a falling edge and counted down by the receiver
	int      hold_left = 0;

	binomial_coefficient_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.request_valid(request_valid),
		.request_stall(request_stall),
		.request      (request),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// exact C(n,r) by acc * (n - i) / (i + 1), saturating once a partial value no longer fits
	function automatic result_t binomial_expected(input request_t req);
		logic [WIDE_BITS-1:0] acc;
		logic [N_WIDTH-1:0]   n;
		logic [N_WIDTH-1:0]   r;
		logic [N_WIDTH-1:0]   k;
		result_t              res;
		n = req.n_items;
		r = req.r_chosen;
		res.coefficient = '0;
		res.overflow = 1'b0;
		// r above n: no subsets at all
		if (r > n)
			return res;
		// use the shorter side, C(n,r) = C(n,n-r)
		k = (n - r < r) ? n - r : r;
		acc = WIDE_BITS'(1);
		for (int i = 0; i < int'(k); i++) begin
			acc = acc * WIDE_BITS'(n - N_WIDTH'(i)) / WIDE_BITS'(i + 1);
			if (acc > COEFF_LIMIT) begin
				res.coefficient = SATURATED;
				res.overflow = 1'b1;
				return res;
			end
		end
		res.coefficient = acc[RESULT_WIDTH-1:0];
		return res;
	endfunction

	// random request, weighted toward values that run many steps without saturating
	function automatic request_t random_request();
		request_t req;
		int       pick;
		int       n_val;
		int       offset;
		pick = $urandom_range(99);
		if (pick < 35) begin
			// small n, full range of r: deep loops that mostly fit
			n_val = $urandom_range(70);
			req.n_items = N_WIDTH'(n_val);
			req.r_chosen = N_WIDTH'($urandom_range(n_val));
		end else if (pick < 60) begin
			n_val = $urandom_range(255);
			req.n_items = N_WIDTH'(n_val);
			req.r_chosen = N_WIDTH'($urandom_range(n_val));
		end else if (pick < 75) begin
			// any n with r close to either end
			n_val = $urandom_range(255);
			offset = $urandom_range(12);
			if (offset > n_val)
				offset = n_val;
			req.n_items = N_WIDTH'(n_val);
			req.r_chosen = N_WIDTH'($urandom_range(1) ? offset : n_val - offset);
		end else if (pick < 85) begin
			// r strictly above n
			n_val = $urandom_range(254);
			req.n_items = N_WIDTH'(n_val);
			req.r_chosen = N_WIDTH'($urandom_range(255, n_val + 1));
		end else begin
			req.n_items = N_WIDTH'($urandom);
			req.r_chosen = N_WIDTH'($urandom);
		end
		return req;
	endfunction

	// offer one request with random gaps ahead of it, then wait until it is taken
	task automatic offer_request(input request_t req, input logic known, input result_t typed);
		while ($urandom_range(99) < send_gap_pct) begin
			request_valid <= 1'b0;
			@(posedge clk);
		end
		request <= req;
		request_valid <= 1'b1;
		@(posedge clk);
		while (request_stall)
			@(posedge clk);
		// taken at this edge
		coefficient_q.push_back(known ? typed : binomial_expected(req));
	endtask

	// sender pauses until every owed coefficient has come back
	task automatic wait_all_results();
		request_valid <= 1'b0;
		while (coefficient_q.size() != 0)
			@(posedge clk);
	endtask

	// receiver: long hold-off when asked, random stalls otherwise
	always @(posedge clk) begin
		if (hold_left > 0) begin
			result_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else begin
			result_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	// compare every taken result with the oldest owed coefficient
	always @(posedge clk) begin : check_results
		result_t owed;
		if (arst_n && result_valid && !result_stall) begin
			if (coefficient_q.size() == 0) begin
				$error("result with nothing owed: coefficient %0d overflow %0b",
					result.coefficient, result.overflow);
				mismatch_count++;
			end else begin
				owed = coefficient_q.pop_front();
				if (result.coefficient !== owed.coefficient) begin
					$error("coefficient: expected %0d, got %0d",
						owed.coefficient, result.coefficient);
					mismatch_count++;
				end
				if (result.overflow !== owed.overflow) begin
					$error("overflow: expected %0b, got %0b", owed.overflow, result.overflow);
					mismatch_count++;
				end
			end
		end
	end

	initial begin : stimulus
		int phase;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table, with the idle rates of the first phase
		send_gap_pct = SEND_GAP_PCT[0];
		recv_stall_pct = RECV_STALL_PCT[0];
		for (int row = 0; row < DIRECTED_ROWS; row++)
			offer_request(DIRECTED[row].req, DIRECTED[row].known, DIRECTED[row].res);

		// random phases: receiver idles more, then sender idles more, then no idling
		for (phase = 0; phase < 3; phase++) begin
			send_gap_pct = SEND_GAP_PCT[phase];
			recv_stall_pct = RECV_STALL_PCT[phase];
			// let the block drain, then hold results back so requests pile up
			wait_all_results();
			@(negedge clk) hold_left = LONG_HOLD;
			@(posedge clk);
			for (int item = 0; item < PHASE_ITEMS; item++)
				offer_request(random_request(), 1'b0, '0);
		end

		wait_all_results();
		// watch a little longer for results nobody asked for
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("binomial_coefficient_unit_tb OK");
		else
			$display("binomial_coefficient_unit_tb NOT OK");
		$finish;
	end

	// hard stop if the block hangs
	initial begin
		#(TIMEOUT_NS);
		$display("binomial_coefficient_unit_tb NOT OK");
		$finish;
	end

endmodule
